// ===== src/lfbc_pkg.sv =====
// Package for the free block cache: shared codes, reset values and types.
// No dependencies; used by every module of the block.
`default_nettype none

package lfbc_pkg;

   // Default sizing
   localparam int DEF_CACHE_DEPTH = 16;
   localparam int DEF_ADDR_BITS   = 48;
   localparam int DEF_SIZE_BITS   = 40;

   // Configuration registers
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_CACHED = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAGE_SHIFT = 4'd1;
   localparam logic [CSR_DATA_BITS-1:0]  MAX_CACHED_RST = 5'd3;
   localparam logic [CSR_DATA_BITS-1:0]  PAGE_SHIFT_RST = 5'd12;
   localparam logic [CSR_DATA_BITS-1:0]  PAGE_SHIFT_MIN = 5'd12;
   localparam logic [CSR_DATA_BITS-1:0]  PAGE_SHIFT_MAX = 5'd16;

   // Request opcodes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_TRIM  = 2'd3;

   // Result kinds
   localparam logic [2:0] KIND_HIT     = 3'd0;
   localparam logic [2:0] KIND_MISS    = 3'd1;
   localparam logic [2:0] KIND_CACHED  = 3'd2;
   localparam logic [2:0] KIND_RELEASE = 3'd3;
   localparam logic [2:0] KIND_INVALID = 3'd4;
   localparam logic [2:0] KIND_DONE    = 3'd5;

   // Request checks, from the checker to the sequencer
   typedef struct packed {
      logic alloc_ok;
      logic free_ok;
   } chk_type;

   // Result control, from the sequencer to the output stage
   typedef struct packed {
      logic [2:0] kind;
      logic       last;
   } rsp_ctl_type;

endpackage

`default_nettype wire

// ===== src/lfbc_check.sv =====
// Request checker: page rounding, overflow and alignment tests, limit clamp.
// Depends on lfbc_pkg.
`default_nettype none

module lfbc_check #(
   parameter int CACHE_DEPTH = 16,
   parameter int ADDR_BITS   = 48,
   parameter int SIZE_BITS   = 40,
   localparam int CW = $clog2(CACHE_DEPTH + 1)
) (
   input  wire logic [4:0]           max_cached,
   input  wire logic [4:0]           page_shift,
   input  wire logic [ADDR_BITS-1:0] block_address,
   input  wire logic [SIZE_BITS-1:0] body_size,
   input  wire logic [SIZE_BITS-1:0] guard_bytes,
   output logic [SIZE_BITS-1:0]      round_size,
   output logic [SIZE_BITS-1:0]      round_guard,
   output logic [CW-1:0]             eff_max,
   output lfbc_pkg::chk_type         chk
);
   import lfbc_pkg::*;

   logic [4:0]           eff_shift;
   logic [SIZE_BITS-1:0] pm_size;
   logic [ADDR_BITS-1:0] pm_addr;
   logic [SIZE_BITS:0]   sum_size;
   logic [SIZE_BITS:0]   sum_guard;

   // Clamp the page shift and build the page masks
   always_comb begin
      if (page_shift < PAGE_SHIFT_MIN) begin
         eff_shift = PAGE_SHIFT_MIN;
      end else if (page_shift > PAGE_SHIFT_MAX) begin
         eff_shift = PAGE_SHIFT_MAX;
      end else begin
         eff_shift = page_shift;
      end
   end

   assign pm_size = ~({SIZE_BITS{1'b1}} << eff_shift);
   assign pm_addr = ~({ADDR_BITS{1'b1}} << eff_shift);

   // Round up; a carry out means the rounded size does not fit
   assign sum_size    = {1'b0, body_size} + {1'b0, pm_size};
   assign sum_guard   = {1'b0, guard_bytes} + {1'b0, pm_size};
   assign round_size  = sum_size[SIZE_BITS-1:0] & ~pm_size;
   assign round_guard = sum_guard[SIZE_BITS-1:0] & ~pm_size;

   always_comb begin
      chk.alloc_ok = !sum_size[SIZE_BITS] && !sum_guard[SIZE_BITS] && (round_size != '0);
      chk.free_ok  = (body_size != '0) && ((body_size & pm_size) == '0)
                     && ((guard_bytes & pm_size) == '0) && ((block_address & pm_addr) == '0);
   end

   // Limit saturates to the cache depth
   always_comb begin
      if (int'(max_cached) > CACHE_DEPTH) begin
         eff_max = CW'(CACHE_DEPTH);
      end else begin
         eff_max = CW'(max_cached);
      end
   end

endmodule

`default_nettype wire

// ===== src/lfbc_rsp_buf.sv =====
// Result output register: holds one result until the transfer completes.
// Depends on lfbc_pkg.
`default_nettype none

module lfbc_rsp_buf #(
   parameter int ADDR_BITS = 48,
   parameter int SIZE_BITS = 40
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire lfbc_pkg::rsp_ctl_type ctl,
   input  wire logic [ADDR_BITS-1:0] load_address,
   input  wire logic [SIZE_BITS-1:0] load_size,
   input  wire logic [SIZE_BITS-1:0] load_guard,
   output logic                      free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_kind,
   output logic [ADDR_BITS-1:0]      rsp_out_address,
   output logic [SIZE_BITS-1:0]      rsp_out_size,
   output logic [SIZE_BITS-1:0]      rsp_out_guard,
   output logic                      rsp_last
);
   import lfbc_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   rsp_ctl_type          ctl_ff;
   logic [ADDR_BITS-1:0] address_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] guard_ff;

   // Slot is free when empty or draining this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         ctl_ff     <= ctl;
         address_ff <= load_address;
         size_ff    <= load_size;
         guard_ff   <= load_guard;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = ctl_ff.kind;
   assign rsp_last        = ctl_ff.last;
   assign rsp_out_address = address_ff;
   assign rsp_out_size    = size_ff;
   assign rsp_out_guard   = guard_ff;

endmodule

`default_nettype wire

// ===== src/lfbc_engine.sv =====
// Sequencer and entry memory: search, evict, shift and insert over the MRU list.
// Depends on lfbc_pkg; fed by lfbc_check, drives lfbc_rsp_buf.
`default_nettype none

module lfbc_engine #(
   parameter int CACHE_DEPTH = 16,
   parameter int ADDR_BITS   = 48,
   parameter int SIZE_BITS   = 40,
   localparam int CW = $clog2(CACHE_DEPTH + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_op,
   input  wire logic [ADDR_BITS-1:0] req_block_address,
   input  wire logic [SIZE_BITS-1:0] req_body_size,
   input  wire logic [SIZE_BITS-1:0] req_guard_bytes,
   output logic [ADDR_BITS-1:0]      cur_address,
   output logic [SIZE_BITS-1:0]      cur_size,
   output logic [SIZE_BITS-1:0]      cur_guard,
   input  wire logic [SIZE_BITS-1:0] round_size,
   input  wire logic [SIZE_BITS-1:0] round_guard,
   input  wire logic [CW-1:0]        eff_max,
   input  wire lfbc_pkg::chk_type    chk,
   input  wire logic                 rsp_free,
   output logic                      emit,
   output lfbc_pkg::rsp_ctl_type     emit_ctl,
   output logic [ADDR_BITS-1:0]      emit_address,
   output logic [SIZE_BITS-1:0]      emit_size,
   output logic [SIZE_BITS-1:0]      emit_guard
);
   import lfbc_pkg::*;

   localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int EW = ADDR_BITS + 2 * SIZE_BITS;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DECIDE   = 4'd1;
   localparam logic [3:0] ST_SRCH_RD  = 4'd2;
   localparam logic [3:0] ST_SRCH_CMP = 4'd3;
   localparam logic [3:0] ST_MISS     = 4'd4;
   localparam logic [3:0] ST_EV_RD    = 4'd5;
   localparam logic [3:0] ST_EV_EMIT  = 4'd6;
   localparam logic [3:0] ST_SHIFT    = 4'd7;
   localparam logic [3:0] ST_MV_RD    = 4'd8;
   localparam logic [3:0] ST_MV_WR    = 4'd9;
   localparam logic [3:0] ST_PUT      = 4'd10;
   localparam logic [3:0] ST_DONE     = 4'd11;

   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        keep_ff, keep_in;
   logic                 up_ff, up_in;
   logic [1:0]           op_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] guard_ff;

   logic [EW-1:0]        entry_mem [CACHE_DEPTH];
   logic [EW-1:0]        rd_data_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;

   logic [CW-1:0]        idx_inc;
   logic [CW-1:0]        idx_dec;
   logic [CW-1:0]        clr_keep;
   logic [ADDR_BITS-1:0] rd_address;
   logic [SIZE_BITS-1:0] rd_size;
   logic [SIZE_BITS-1:0] rd_guard;
   logic                 match;
   logic                 accept;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign cur_address = addr_ff;
   assign cur_size    = size_ff;
   assign cur_guard   = guard_ff;

   assign idx_inc    = idx_ff + CW'(1);
   assign idx_dec    = idx_ff - CW'(1);
   assign clr_keep   = (op_ff == OP_CLEAR) ? '0 : eff_max;
   assign rd_guard   = rd_data_ff[SIZE_BITS-1:0];
   assign rd_size    = rd_data_ff[2*SIZE_BITS-1:SIZE_BITS];
   assign rd_address = rd_data_ff[EW-1:2*SIZE_BITS];
   assign match      = (rd_size == round_size) && (rd_guard == round_guard);

   // Entry memory with a registered read; the sequencer never reads and
   // writes in the same cycle, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      keep_in      = keep_ff;
      up_in        = up_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data_ff;
      emit         = 1'b0;
      emit_ctl     = '{kind: KIND_DONE, last: 1'b1};
      emit_address = '0;
      emit_size    = '0;
      emit_guard   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (op_ff)
               OP_ALLOC: begin
                  if (!chk.alloc_ok) begin
                     if (rsp_free) begin
                        emit     = 1'b1;
                        emit_ctl = '{kind: KIND_INVALID, last: 1'b1};
                        state_in = ST_IDLE;
                     end
                  end else if (count_ff == '0) begin
                     state_in = ST_MISS;
                  end else begin
                     idx_in   = '0;
                     state_in = ST_SRCH_RD;
                  end
               end
               OP_FREE: begin
                  if (!chk.free_ok) begin
                     if (rsp_free) begin
                        emit     = 1'b1;
                        emit_ctl = '{kind: KIND_INVALID, last: 1'b1};
                        state_in = ST_IDLE;
                     end
                  end else if (eff_max == '0) begin
                     // nothing may be kept: hand the block straight back
                     if (rsp_free) begin
                        emit         = 1'b1;
                        emit_ctl     = '{kind: KIND_RELEASE, last: 1'b1};
                        emit_address = addr_ff;
                        emit_size    = size_ff;
                        emit_guard   = guard_ff;
                        state_in     = ST_IDLE;
                     end
                  end else begin
                     keep_in = eff_max - CW'(1);
                     if (count_ff > eff_max - CW'(1)) begin
                        idx_in   = eff_max - CW'(1);
                        state_in = ST_EV_RD;
                     end else begin
                        state_in = ST_SHIFT;
                     end
                  end
               end
               default: begin
                  keep_in = clr_keep;
                  if (count_ff > clr_keep) begin
                     idx_in   = clr_keep;
                     state_in = ST_EV_RD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            endcase
         end
         ST_SRCH_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (match) begin
               // hit: report, then close the gap from above
               if (rsp_free) begin
                  emit         = 1'b1;
                  emit_ctl     = '{kind: KIND_HIT, last: 1'b1};
                  emit_address = rd_address;
                  emit_size    = round_size;
                  emit_guard   = round_guard;
                  idx_in       = idx_inc;
                  up_in        = 1'b0;
                  state_in     = ST_MV_RD;
               end
            end else if (idx_inc == count_ff) begin
               state_in = ST_MISS;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_SRCH_RD;
            end
         end
         ST_MISS: begin
            if (rsp_free) begin
               emit       = 1'b1;
               emit_ctl   = '{kind: KIND_MISS, last: 1'b1};
               emit_size  = round_size;
               emit_guard = round_guard;
               state_in   = ST_IDLE;
            end
         end
         ST_EV_RD: begin
            rd_en    = 1'b1;
            state_in = ST_EV_EMIT;
         end
         ST_EV_EMIT: begin
            if (rsp_free) begin
               emit         = 1'b1;
               emit_ctl     = '{kind: KIND_RELEASE, last: 1'b0};
               emit_address = rd_address;
               emit_size    = rd_size;
               emit_guard   = rd_guard;
               if (idx_inc == count_ff) begin
                  count_in = keep_ff;
                  state_in = (op_ff == OP_FREE) ? ST_SHIFT : ST_DONE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = ST_EV_RD;
               end
            end
         end
         ST_SHIFT: begin
            // make room at the most recent end, oldest entry first
            if (count_ff == '0) begin
               state_in = ST_PUT;
            end else begin
               idx_in   = count_ff - CW'(1);
               up_in    = 1'b1;
               state_in = ST_MV_RD;
            end
         end
         ST_MV_RD: begin
            if (!up_ff && (idx_ff >= count_ff)) begin
               count_in = count_ff - CW'(1);
               state_in = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_MV_WR;
            end
         end
         ST_MV_WR: begin
            wr_en = 1'b1;
            if (up_ff) begin
               wr_addr = idx_inc[AW-1:0];
               if (idx_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  idx_in   = idx_dec;
                  state_in = ST_MV_RD;
               end
            end else begin
               wr_addr  = idx_dec[AW-1:0];
               idx_in   = idx_inc;
               state_in = ST_MV_RD;
            end
         end
         ST_PUT: begin
            if (rsp_free) begin
               wr_en        = 1'b1;
               wr_addr      = '0;
               wr_data      = {addr_ff, size_ff, guard_ff};
               count_in     = count_ff + CW'(1);
               emit         = 1'b1;
               emit_ctl     = '{kind: KIND_CACHED, last: 1'b1};
               emit_address = addr_ff;
               emit_size    = size_ff;
               emit_guard   = guard_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               emit     = 1'b1;
               emit_ctl = '{kind: KIND_DONE, last: 1'b1};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         keep_ff  <= '0;
         up_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         keep_ff  <= keep_in;
         up_ff    <= up_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         addr_ff  <= req_block_address;
         size_ff  <= req_body_size;
         guard_ff <= req_guard_bytes;
      end
   end

   // Checks
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> rsp_free)
      else $error("result issued while output register busy");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("entry memory read and written in one cycle");

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DECIDE))
      else $error("accepted request not decoded");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_ctl.last) |=> (state_ff == ST_IDLE || state_ff == ST_MV_RD))
      else $error("work continues past final result");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CACHE_DEPTH)
      else $error("entry count exceeds depth");

endmodule

`default_nettype wire

// ===== src/lru_free_block_cache.sv =====
// Free block cache top: one request in flight; the entry memory takes one access at a time.
// An invalid request or direct release gives one result. Alloc searches from the newest
// entry; a hit then moves older entries to close the gap. Free releases entries over the
// limit, shifts, inserts; clear releases all, trim those over the limit. Synchronous reset
// clears control, count and the configuration registers; no memory sweep.
// Depends on lfbc_pkg, lfbc_check, lfbc_engine, lfbc_rsp_buf.
`default_nettype none

module lru_free_block_cache #(
   parameter int CACHE_DEPTH = lfbc_pkg::DEF_CACHE_DEPTH,
   parameter int ADDR_BITS   = lfbc_pkg::DEF_ADDR_BITS,
   parameter int SIZE_BITS   = lfbc_pkg::DEF_SIZE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_op,
   input  wire logic [ADDR_BITS-1:0]                req_block_address,
   input  wire logic [SIZE_BITS-1:0]                req_body_size,
   input  wire logic [SIZE_BITS-1:0]                req_guard_bytes,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [2:0]                               rsp_kind,
   output logic [ADDR_BITS-1:0]                     rsp_out_address,
   output logic [SIZE_BITS-1:0]                     rsp_out_size,
   output logic [SIZE_BITS-1:0]                     rsp_out_guard,
   output logic                                     rsp_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lfbc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lfbc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import lfbc_pkg::*;

   localparam int CW = $clog2(CACHE_DEPTH + 1);

   logic [CSR_DATA_BITS-1:0] max_cached_ff;
   logic [CSR_DATA_BITS-1:0] page_shift_ff;

   logic [ADDR_BITS-1:0] cur_address;
   logic [SIZE_BITS-1:0] cur_size;
   logic [SIZE_BITS-1:0] cur_guard;
   logic [SIZE_BITS-1:0] round_size;
   logic [SIZE_BITS-1:0] round_guard;
   logic [CW-1:0]        eff_max;
   chk_type              chk;
   logic                 rsp_free;
   logic                 emit;
   rsp_ctl_type          emit_ctl;
   logic [ADDR_BITS-1:0] emit_address;
   logic [SIZE_BITS-1:0] emit_size;
   logic [SIZE_BITS-1:0] emit_guard;

   // Configuration registers; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cached_ff <= MAX_CACHED_RST;
         page_shift_ff <= PAGE_SHIFT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_CACHED: max_cached_ff <= csr_data;
            CSR_PAGE_SHIFT: page_shift_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   lfbc_check #(
      .CACHE_DEPTH (CACHE_DEPTH),
      .ADDR_BITS   (ADDR_BITS),
      .SIZE_BITS   (SIZE_BITS)
   ) u_check (
      .max_cached    (max_cached_ff),
      .page_shift    (page_shift_ff),
      .block_address (cur_address),
      .body_size     (cur_size),
      .guard_bytes   (cur_guard),
      .round_size    (round_size),
      .round_guard   (round_guard),
      .eff_max       (eff_max),
      .chk           (chk)
   );

   lfbc_engine #(
      .CACHE_DEPTH (CACHE_DEPTH),
      .ADDR_BITS   (ADDR_BITS),
      .SIZE_BITS   (SIZE_BITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_block_address (req_block_address),
      .req_body_size     (req_body_size),
      .req_guard_bytes   (req_guard_bytes),
      .cur_address       (cur_address),
      .cur_size          (cur_size),
      .cur_guard         (cur_guard),
      .round_size        (round_size),
      .round_guard       (round_guard),
      .eff_max           (eff_max),
      .chk               (chk),
      .rsp_free          (rsp_free),
      .emit              (emit),
      .emit_ctl          (emit_ctl),
      .emit_address      (emit_address),
      .emit_size         (emit_size),
      .emit_guard        (emit_guard)
   );

   lfbc_rsp_buf #(
      .ADDR_BITS (ADDR_BITS),
      .SIZE_BITS (SIZE_BITS)
   ) u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .load            (emit),
      .ctl             (emit_ctl),
      .load_address    (emit_address),
      .load_size       (emit_size),
      .load_guard      (emit_guard),
      .free            (rsp_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_out_address (rsp_out_address),
      .rsp_out_size    (rsp_out_size),
      .rsp_out_guard   (rsp_out_guard),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sim/tb_lru_free_block_cache.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_free_block_cache: random and directed
// alloc/free/clear/trim traffic, checked against an in-bench cache predictor.
// Depends on lfbc_pkg and the lru_free_block_cache RTL.

module tb_lru_free_block_cache;
   import lfbc_pkg::*;

   localparam int DEPTH  = DEF_CACHE_DEPTH;
   localparam int ADDR_W = DEF_ADDR_BITS;
   localparam int SIZE_W = DEF_SIZE_BITS;
   localparam logic [63:0] SIZE_LIMIT = (64'd1 << SIZE_W) - 1;
   localparam logic [63:0] ADDR_LIMIT = (64'd1 << ADDR_W) - 1;

   // index that maps to no register; writes to it must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 4'd9;

   localparam int NUM_PHASES       = 8;
   localparam int ITEMS_PER_PHASE  = 60;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [2:0]        kind;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] guard;
      logic              last;
   } cache_result_type;

   // Predicts the result stream of the cache and checks the actual one
   class free_cache_scoreboard;
      cache_result_type  pending[$];
      logic [ADDR_W-1:0] slot_addr[DEPTH];
      logic [SIZE_W-1:0] slot_size[DEPTH];
      logic [SIZE_W-1:0] slot_guard[DEPTH];
      int                slot_count;
      int                max_cached;
      int                page_shift;
      int                errors;
      int                checked;
      int                hits;
      int                releases;

      function new();
         slot_count = 0;
         max_cached = MAX_CACHED_RST;
         page_shift = PAGE_SHIFT_RST;
         errors     = 0;
         checked    = 0;
         hits       = 0;
         releases   = 0;
      endfunction

      function void apply_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         if (idx == CSR_MAX_CACHED) begin
            max_cached = val;
         end else if (idx == CSR_PAGE_SHIFT) begin
            page_shift = val;
         end
      endfunction

      function logic [63:0] page_mask();
         int sh;
         sh = page_shift;
         if (sh < PAGE_SHIFT_MIN) sh = PAGE_SHIFT_MIN;
         if (sh > PAGE_SHIFT_MAX) sh = PAGE_SHIFT_MAX;
         return (64'd1 << sh) - 1;
      endfunction

      function void emit(logic [2:0] kind, logic [63:0] a, logic [63:0] s, logic [63:0] g);
         cache_result_type r;
         r.kind  = kind;
         r.addr  = a[ADDR_W-1:0];
         r.size  = s[SIZE_W-1:0];
         r.guard = g[SIZE_W-1:0];
         r.last  = 1'b0;
         pending.push_back(r);
      endfunction

      // page round-up; fails when the result does not fit in the size field
      function bit round_up(logic [63:0] v, logic [63:0] pm, output logic [63:0] res);
         res = 64'd0;
         if (v > SIZE_LIMIT - pm) return 1'b0;
         res = (v + pm) & ~pm;
         return 1'b1;
      endfunction

      function void remove_at(int idx);
         for (int j = idx; j + 1 < slot_count; j++) begin
            slot_addr[j]  = slot_addr[j+1];
            slot_size[j]  = slot_size[j+1];
            slot_guard[j] = slot_guard[j+1];
         end
         if (slot_count > 0) slot_count--;
      endfunction

      // release everything from slot keep onward, newest first
      function void evict_to(int keep);
         if (slot_count <= keep) return;
         for (int i = keep; i < slot_count; i++) begin
            emit(KIND_RELEASE, slot_addr[i], slot_size[i], slot_guard[i]);
         end
         slot_count = keep;
      endfunction

      function void note_request(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                 logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] guard);
         logic [63:0]      pm;
         logic [63:0]      rs;
         logic [63:0]      rg;
         int               lim;
         bit               ok;
         bit               hit;
         cache_result_type r;
         pm  = page_mask();
         lim = (max_cached > DEPTH) ? DEPTH : max_cached;
         case (op)
            OP_ALLOC: begin
               ok = round_up(size, pm, rs);
               if (ok) ok = round_up(guard, pm, rg);
               if (ok && rs == 64'd0) ok = 1'b0;
               if (!ok) begin
                  emit(KIND_INVALID, 0, 0, 0);
               end else begin
                  hit = 1'b0;
                  for (int i = 0; i < slot_count && !hit; i++) begin
                     if (slot_size[i] == rs[SIZE_W-1:0] && slot_guard[i] == rg[SIZE_W-1:0]) begin
                        emit(KIND_HIT, slot_addr[i], rs, rg);
                        remove_at(i);
                        hit = 1'b1;
                     end
                  end
                  if (!hit) emit(KIND_MISS, 0, rs, rg);
               end
            end
            OP_FREE: begin
               if (size == 0 || (size & pm) != 0 || (guard & pm) != 0 || (addr & pm) != 0) begin
                  emit(KIND_INVALID, 0, 0, 0);
               end else if (lim == 0) begin
                  emit(KIND_RELEASE, addr, size, guard);
               end else begin
                  evict_to(lim - 1);
                  for (int i = slot_count; i > 0; i--) begin
                     if (i < DEPTH) begin
                        slot_addr[i]  = slot_addr[i-1];
                        slot_size[i]  = slot_size[i-1];
                        slot_guard[i] = slot_guard[i-1];
                     end
                  end
                  slot_addr[0]  = addr;
                  slot_size[0]  = size;
                  slot_guard[0] = guard;
                  if (slot_count < DEPTH) slot_count++;
                  emit(KIND_CACHED, addr, size, guard);
               end
            end
            default: begin
               evict_to(op == OP_CLEAR ? 0 : lim);
               emit(KIND_DONE, 0, 0, 0);
            end
         endcase
         // final result of this request carries last
         r = pending.pop_back();
         r.last = 1'b1;
         pending.push_back(r);
      endfunction

      function void check_result(logic [2:0] kind, logic [ADDR_W-1:0] addr,
                                 logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] guard,
                                 logic last);
         cache_result_type want;
         checked++;
         if (kind == KIND_HIT) hits++;
         if (kind == KIND_RELEASE) releases++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("[%0t] unexpected result kind=%0d addr=%h size=%h guard=%h last=%b",
                        $realtime, kind, addr, size, guard, last);
            return;
         end
         want = pending.pop_front();
         if (want.kind !== kind || want.addr !== addr || want.size !== size ||
             want.guard !== guard || want.last !== last) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("[%0t] mismatch on result %0d", $realtime, checked);
               $display("   expected kind=%0d addr=%h size=%h guard=%h last=%b",
                        want.kind, want.addr, want.size, want.guard, want.last);
               $display("   actual   kind=%0d addr=%h size=%h guard=%h last=%b",
                        kind, addr, size, guard, last);
            end
         end
      endfunction
   endclass

   // DUT ports; the driven inputs are known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_op = OP_ALLOC;
   logic [ADDR_W-1:0]         req_block_address = '0;
   logic [SIZE_W-1:0]         req_body_size = '0;
   logic [SIZE_W-1:0]         req_guard_bytes = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [2:0]                rsp_kind;
   logic [ADDR_W-1:0]         rsp_out_address;
   logic [SIZE_W-1:0]         rsp_out_size;
   logic [SIZE_W-1:0]         rsp_out_guard;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   free_cache_scoreboard sb = new();
   bit gaps_on   = 1'b0;
   bit long_hold = 1'b0;
   int idle_cycles = 0;
   int requests = 0;
   int directed = 0;

   lru_free_block_cache dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_block_address (req_block_address),
      .req_body_size     (req_body_size),
      .req_guard_bytes   (req_guard_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_address   (rsp_out_address),
      .rsp_out_size      (rsp_out_size),
      .rsp_out_guard     (rsp_out_guard),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // idle stretch: mostly short, now and then long
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Result checking at each transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_kind, rsp_out_address, rsp_out_size, rsp_out_guard, rsp_last);
   end

   // Receiver back-pressure, including one long hold-off on request
   initial begin : rsp_sink
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            stall = LONG_HOLD_CYCLES;
            long_hold = 1'b0;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (!gaps_on || $urandom_range(0, 99) < 75) begin
            rsp_ready <= 1'b1;
         end else begin
            stall = idle_len() - 1;
            rsp_ready <= 1'b0;
         end
      end
   end

   // Watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("[%0t] no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // One request transfer, then an optional sender gap
   task automatic request(input logic [1:0] op, input logic [63:0] a,
                          input logic [63:0] s, input logic [63:0] g);
      int gap;
      req_valid         <= 1'b1;
      req_op            <= op;
      req_block_address <= a[ADDR_W-1:0];
      req_body_size     <= s[SIZE_W-1:0];
      req_guard_bytes   <= g[SIZE_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, a[ADDR_W-1:0], s[SIZE_W-1:0], g[SIZE_W-1:0]);
      requests++;
      gap = 0;
      if (gaps_on && $urandom_range(0, 99) >= 55) gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every predicted result is back, then let the block finish
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Back-to-back register writes; the caller drops valid after the last one
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.apply_csr(idx, val);
   endtask

   // Random traffic, mostly well-formed size classes so allocs hit often
   task automatic random_item();
      int          r;
      int          k;
      int          gk;
      logic [63:0] pm;
      logic [63:0] page;
      logic [63:0] a;
      logic [63:0] s;
      logic [63:0] g;
      pm   = sb.page_mask();
      page = pm + 1;
      r    = $urandom_range(0, 99);
      k    = $urandom_range(1, 4);
      gk   = $urandom_range(0, 2);
      a    = rand64() & ADDR_LIMIT & ~pm;
      s    = k * page;
      g    = gk * page;
      if (r < 38) begin
         s = s - $urandom_range(0, page - 1);
         if (gk != 0) g = g - $urandom_range(0, page - 1);
         request(OP_ALLOC, rand64(), s, g);
      end else if (r < 74) begin
         request(OP_FREE, a, s, g);
      end else if (r < 78) begin
         // large aligned block, exercises the upper size bits
         s = rand64() & SIZE_LIMIT & ~pm;
         if (s == 0) s = page;
         g = rand64() & SIZE_LIMIT & ~pm;
         request(OP_FREE, a, s, g);
      end else if (r < 81) begin
         request(OP_CLEAR, rand64(), rand64(), rand64());
      end else if (r < 88) begin
         request(OP_TRIM, rand64(), rand64(), rand64());
      end else if (r < 93) begin
         // free with one field off the page grid
         case ($urandom_range(0, 2))
            0: a = a + $urandom_range(1, pm);
            1: s = s + $urandom_range(1, pm);
            default: g = g + $urandom_range(1, pm);
         endcase
         request(OP_FREE, a, s, g);
      end else begin
         request(2'($urandom_range(0, 3)), rand64(), rand64(), rand64());
      end
   endtask

   // Main sequence
   initial begin : stimulus
      int max_set;
      int shift_set;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) wait_for_results();
         case (phase)
            0:       begin max_set = 3;  shift_set = 12; end
            1:       begin max_set = 0;  shift_set = 12; end
            2:       begin max_set = 16; shift_set = 16; end
            3:       begin max_set = 31; shift_set = 0;  end
            4:       begin max_set = 1;  shift_set = 31; end
            5:       begin max_set = 8;  shift_set = 13; end
            6:       begin max_set = 2;  shift_set = 14; end
            default: begin max_set = 5;  shift_set = 15; end
         endcase
         if (phase == 0) write_csr(CSR_SPARE_INDEX, 5'd0);
         write_csr(CSR_MAX_CACHED, max_set[CSR_DATA_BITS-1:0]);
         write_csr(CSR_PAGE_SHIFT, shift_set[CSR_DATA_BITS-1:0]);
         csr_valid <= 1'b0;
         gaps_on = (phase % 3) != 0;

         if (phase == 0) begin
            // bad alloc sizes: zero, body overflow, guard overflow
            request(OP_ALLOC, 64'h0, 64'h0, 64'h0);
            request(OP_ALLOC, ADDR_LIMIT, SIZE_LIMIT, 64'h0);
            request(OP_ALLOC, 64'h0, 64'h1, SIZE_LIMIT);
            // misses, including the largest size that still rounds
            request(OP_ALLOC, 64'h0, 64'h1, 64'h1);
            request(OP_ALLOC, 64'h0, SIZE_LIMIT - 64'hfff, SIZE_LIMIT - 64'hfff);
            // bad frees: zero size, off-page address, size and guard
            request(OP_FREE, 64'h1000, 64'h0, 64'h0);
            request(OP_FREE, 64'h1001, 64'h1000, 64'h0);
            request(OP_FREE, 64'h2000, 64'h1800, 64'h0);
            request(OP_FREE, 64'h3000, 64'h1000, 64'h10);
            // clear and trim on an empty cache still give done
            request(OP_CLEAR, 64'h0, 64'h0, 64'h0);
            request(OP_TRIM, 64'h0, 64'h0, 64'h0);
            // fill past max_cached so the oldest gets evicted
            request(OP_FREE, 64'h1000_0000, 64'h1000, 64'h0);
            request(OP_FREE, 64'h2000_0000, 64'h2000, 64'h1000);
            request(OP_FREE, 64'h3000_0000, 64'h3000, 64'h0);
            request(OP_FREE, 64'h4000_0000, 64'h4000, 64'h2000);
            request(OP_FREE, ADDR_LIMIT & ~64'hfff, SIZE_LIMIT & ~64'hfff,
                    SIZE_LIMIT & ~64'hfff);
            // hit at the oldest entry of the list, then a miss
            request(OP_ALLOC, 64'h0, 64'h2f9c, 64'h0);
            request(OP_ALLOC, 64'h0, 64'h5000, 64'h0);
            request(OP_TRIM, 64'h0, 64'h0, 64'h0);
            // two equal blocks: the newer one must be handed out
            request(OP_FREE, 64'h5000_0000, 64'h2000, 64'h1000);
            request(OP_FREE, 64'h6000_0000, 64'h2000, 64'h1000);
            request(OP_ALLOC, 64'h0, 64'h1ffb, 64'hfff);
            request(OP_CLEAR, 64'h0, 64'h0, 64'h0);
            directed = requests;
         end
         // receiver stalls long enough to back the block up
         if (phase == 2) long_hold = 1'b1;
         repeat (ITEMS_PER_PHASE) random_item();
      end

      wait_for_results();
      if (sb.pending.size() != 0) begin
         sb.errors += sb.pending.size();
         $display("%0d expected results never arrived", sb.pending.size());
      end
      $display("Covered %0d requests (%0d directed) over %0d register settings;",
               requests, directed, NUM_PHASES);
      $display("checked %0d results: %0d hits, %0d releases, %0d failures.",
               sb.checked, sb.hits, sb.releases, sb.errors);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
